### design/gamepad_poll_host_unit_defines.svh
// ----------------------------------------------------------------------------
// gamepad poll host assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_POLL_HOST_UNIT_DEFINES_SVH
`define GAMEPAD_POLL_HOST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define GPH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gph port check failed");

// next-cycle implication, sampled on clk, off while in reset
`define GPH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gph port check failed");

`endif

### design/gph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gph_pkg
// types, link constants and byte decode helpers of the gamepad poll host
// ----------------------------------------------------------------------------
package gph_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LOW  = 2'd1,
		PH_HIGH = 2'd2
	} phase_t;

	localparam logic [7:0] CMD_START    = 8'h01;
	localparam logic [7:0] CMD_POLL     = 8'h42;
	localparam logic [7:0] CMD_IDLE     = 8'hFF;
	localparam logic [7:0] ACK_BYTE     = 8'h5A;
	localparam logic [7:0] ID_DIGITAL   = 8'h41;
	localparam logic [7:0] ID_ANALOG    = 8'h23;
	localparam logic [7:0] ID_ANALOG_R  = 8'h73;
	localparam logic [7:0] ID_GREEN     = 8'h53;
	localparam logic [7:0] ID_MOUSE     = 8'h5A;
	localparam logic [7:0] STICK_CENTER = 8'd127;
	localparam logic [7:0] ID_RESET     = 8'hFF;
	localparam logic [7:0] GREEN_MASK0  = 8'hF8;

	// number of data bytes that follow the header, zero for unknown ids
	function automatic logic [3:0] data_len(input logic [7:0] id);
		logic [3:0] n;
		unique case (id)
			ID_DIGITAL:                      n = 4'd2;
			ID_MOUSE:                        n = 4'd4;
			ID_ANALOG, ID_ANALOG_R, ID_GREEN: n = 4'd6;
			default:                         n = 4'd0;
		endcase
		return n;
	endfunction

	// green mode second button byte remap
	function automatic logic [7:0] green_remap(input logic [7:0] t);
		logic [7:0] v;
		v    = t & 8'h61;
		v[2] = t[1];
		v[7] = t[2];
		v[4] = t[3];
		v[3] = t[4];
		v[1] = t[7];
		return v;
	endfunction

	// mouse buttons land on bits 5 and 6
	function automatic logic [7:0] mouse_remap(input logic [7:0] t);
		logic [7:0] v;
		v    = 8'd0;
		v[5] = t[1];
		v[6] = t[2];
		return v;
	endfunction

endpackage

### design/gamepad_poll_host_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_poll_host_unit
// tick driven serial host that polls a game controller and keeps its report
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   ------------------------   ------------------------------------
//  in        in_valid / in_ready        start_poll, data_line (one tick)
//  out       out_valid / out_ready      pin levels, poll_done, poll_ok,
//                                       device_id, six report bytes
//  cfg       cfg_write_en               cfg_write_data -> half period
//
// one item per clock while results are taken: an item is held in the input
// register, then one pass of the sequencer step updates the state and result
// registers; result valid is set by that step and clears once taken
// a stalled result holds the sequencer; while the result waits, the input
// register takes an item only if empty, and fills at most one item deep
// asynchronous reset puts the host idle with id 255 and centered sticks
//
module gamepad_poll_host_unit (
	input  logic       clk,
	input  logic       arst_n,
	// input item channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start_poll,
	input  logic       data_line,
	// result item channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       attention_level,
	output logic       clock_level,
	output logic       command_level,
	output logic       poll_done,
	output logic       poll_ok,
	output logic [7:0] device_id,
	output logic [7:0] buttons_first,
	output logic [7:0] buttons_second,
	output logic [7:0] right_x,
	output logic [7:0] right_y,
	output logic [7:0] left_x,
	output logic [7:0] left_y,
	// configuration
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data
);

	// half period register
	logic [7:0] half_q;

	// input register stage
	logic valid_s1;
	logic start_s1;
	logic data_s1;

	// sequencer state, also the result register
	gph_pkg::phase_t phase_q, phase_d;
	logic [3:0] byte_q, byte_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] wait_q, wait_d;
	logic [7:0] send_q, send_d;
	logic [7:0] recv_q, recv_d;
	logic [7:0] id_q, id_d;
	logic [7:0] report_q [6];
	logic [7:0] report_d [6];
	logic       ok_q, ok_d;
	logic       done_q, done_d;
	logic       out_valid_q;

	// step control
	logic       advance;
	logic [7:0] reload;
	logic [3:0] n_len;
	logic [3:0] d_idx;
	logic [7:0] inv_r;

	// the step runs when an item is held and the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// a zero half period behaves as one tick
	assign reload = (half_q == 8'd0) ? 8'd0 : half_q - 8'd1;
	assign n_len  = gph_pkg::data_len(id_q);
	assign d_idx  = byte_q - 4'd3;
	assign inv_r  = ~recv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 8'd10;
		end else if (cfg_write_en) begin
			half_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			start_s1 <= 1'b0;
			data_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			start_s1 <= start_poll;
			data_s1  <= data_line;
		end
	end

	// one tick of the pin sequencer
	always_comb begin
		phase_d  = phase_q;
		byte_d   = byte_q;
		bit_d    = bit_q;
		wait_d   = wait_q;
		send_d   = send_q;
		recv_d   = recv_q;
		id_d     = id_q;
		report_d = report_q;
		ok_d     = ok_q;
		done_d   = 1'b0;

		unique case (phase_q)
			gph_pkg::PH_LOW: begin
				if (wait_q != 8'd0) begin
					wait_d = wait_q - 8'd1;
				end else begin
					// end of the low half: sample data, raise clock
					if (data_s1) begin
						recv_d = recv_q | (8'd1 << bit_q);
					end
					phase_d = gph_pkg::PH_HIGH;
					wait_d  = reload;
				end
			end
			gph_pkg::PH_HIGH: begin
				if (wait_q != 8'd0) begin
					wait_d = wait_q - 8'd1;
				end else if (bit_q != 3'd7) begin
					// next bit of the same byte
					bit_d   = bit_q + 3'd1;
					send_d  = send_q >> 1;
					phase_d = gph_pkg::PH_LOW;
					wait_d  = reload;
				end else begin
					// end of byte; default is to start the next byte
					bit_d   = 3'd0;
					recv_d  = 8'd0;
					phase_d = gph_pkg::PH_LOW;
					wait_d  = reload;
					send_d  = gph_pkg::CMD_IDLE;
					byte_d  = byte_q + 4'd1;
					if (byte_q == 4'd0) begin
						send_d = gph_pkg::CMD_POLL;
					end else if (byte_q == 4'd1) begin
						id_d = recv_q;
					end else if (byte_q == 4'd2) begin
						// no acknowledge or unknown id: abort
						if (recv_q != gph_pkg::ACK_BYTE || n_len == 4'd0) begin
							phase_d = gph_pkg::PH_IDLE;
							done_d  = 1'b1;
						end
					end else begin
						// data byte
						if (id_q == gph_pkg::ID_MOUSE) begin
							case (d_idx)
								4'd1: begin
									report_d[0] = 8'd0;
									report_d[1] = gph_pkg::mouse_remap(inv_r);
								end
								4'd2: report_d[2] = recv_q;
								4'd3: report_d[3] = recv_q;
								default: ;
							endcase
						end else begin
							case (d_idx)
								4'd0: report_d[0] = (id_q == gph_pkg::ID_GREEN) ?
									(inv_r & gph_pkg::GREEN_MASK0) : inv_r;
								4'd1: report_d[1] = (id_q == gph_pkg::ID_GREEN) ?
									gph_pkg::green_remap(inv_r) : inv_r;
								4'd2: report_d[2] = recv_q;
								4'd3: report_d[3] = recv_q;
								4'd4: report_d[4] = recv_q;
								4'd5: report_d[5] = recv_q;
								default: ;
							endcase
						end
						// last data byte finishes the poll
						if ((byte_q - 4'd2) >= n_len) begin
							ok_d    = 1'b1;
							phase_d = gph_pkg::PH_IDLE;
							done_d  = 1'b1;
						end
					end
				end
			end
			default: begin
				// idle: a start request opens a poll with the first command bit
				phase_d = gph_pkg::PH_IDLE;
				if (start_s1) begin
					ok_d        = 1'b0;
					report_d[0] = 8'd0;
					report_d[1] = 8'd0;
					report_d[2] = gph_pkg::STICK_CENTER;
					report_d[3] = gph_pkg::STICK_CENTER;
					report_d[4] = gph_pkg::STICK_CENTER;
					report_d[5] = gph_pkg::STICK_CENTER;
					byte_d      = 4'd0;
					send_d      = gph_pkg::CMD_START;
					bit_d       = 3'd0;
					recv_d      = 8'd0;
					phase_d     = gph_pkg::PH_LOW;
					wait_d      = reload;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= gph_pkg::PH_IDLE;
			byte_q      <= 4'd0;
			bit_q       <= 3'd0;
			wait_q      <= 8'd0;
			send_q      <= 8'd0;
			recv_q      <= 8'd0;
			id_q        <= gph_pkg::ID_RESET;
			report_q[0] <= 8'd0;
			report_q[1] <= 8'd0;
			report_q[2] <= gph_pkg::STICK_CENTER;
			report_q[3] <= gph_pkg::STICK_CENTER;
			report_q[4] <= gph_pkg::STICK_CENTER;
			report_q[5] <= gph_pkg::STICK_CENTER;
			ok_q        <= 1'b0;
			done_q      <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			byte_q   <= byte_d;
			bit_q    <= bit_d;
			wait_q   <= wait_d;
			send_q   <= send_d;
			recv_q   <= recv_d;
			id_q     <= id_d;
			report_q <= report_d;
			ok_q     <= ok_d;
			done_q   <= done_d;
		end
	end

	// result valid follows the step, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result fields come straight from the state after the step
	assign out_valid       = out_valid_q;
	assign attention_level = (phase_q == gph_pkg::PH_IDLE);
	assign clock_level     = (phase_q != gph_pkg::PH_LOW);
	assign command_level   = (phase_q == gph_pkg::PH_IDLE) ? 1'b1 : send_q[0];
	assign poll_done       = done_q;
	assign poll_ok         = ok_q;
	assign device_id       = id_q;
	assign buttons_first   = report_q[0];
	assign buttons_second  = report_q[1];
	assign right_x         = report_q[2];
	assign right_y         = report_q[3];
	assign left_x          = report_q[4];
	assign left_y          = report_q[5];

endmodule

### design/gph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gph_checker
// port level checks of the gamepad poll host, bound to the top level
// ----------------------------------------------------------------------------
`include "gamepad_poll_host_unit_defines.svh"

module gph_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       attention_level,
	input logic       clock_level,
	input logic       command_level,
	input logic       poll_done,
	input logic       poll_ok,
	input logic [7:0] device_id
);

	// a waiting result holds
	`GPH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(device_id))

	// a finished or aborted poll leaves attention high
	`GPH_ASSERT_IMPL(a_done_idle, out_valid && poll_done, attention_level)

	// ok is cleared while a poll runs
	`GPH_ASSERT_IMPL(a_ok_busy, out_valid && !attention_level, !poll_ok)

	// idle link keeps clock and command high
	`GPH_ASSERT_IMPL(a_idle_lines, out_valid && attention_level, clock_level && command_level)

endmodule

bind gamepad_poll_host_unit gph_checker u_gph_checker (.*);
